// File: hdl/gocd_pkg.sv
// Package for the gyro offset calibration and deglitch block.
// Holds field widths, register reset values, register indexes and the control struct.
// Used by every module of the block.
package gocd_pkg;

    localparam int RATE_W   = 14;
    localparam int OUT_W    = 16;
    localparam int CNT_W    = 10;
    localparam int SUM_W    = 24;
    localparam int OFF_SHIFT = 9;
    localparam int CFG_W    = 14;
    localparam int CFG_AW   = 2;

    localparam int CAL_SAMPLES_DEF   = 512;
    localparam int RESTART_COUNT_DEF = 1000;

    localparam logic [CFG_AW-1:0] CFG_FAILSAFE = 2'd0;
    localparam logic [CFG_AW-1:0] CFG_TILT     = 2'd1;
    localparam logic [CFG_AW-1:0] CFG_GLITCH   = 2'd2;

    localparam logic              FAILSAFE_RST = 1'b0;
    localparam logic [CFG_W-1:0]  TILT_RST     = 14'd8;
    localparam logic [CFG_W-1:0]  GLITCH_RST   = 14'd800;

    typedef struct packed {
        logic fire;
        logic cal;
        logic first;
        logic done;
        logic check;
        logic failsafe;
    } t_cal_ctrl;

endpackage

// File: hdl/gocd_ctrl.sv
// Calibration sequencer: countdown and its remainder modulo ten.
// Drives the per-request control struct shared by the three axis datapaths.
// Depends on gocd_pkg.
module gocd_ctrl #(
    parameter int CAL_SAMPLES   = gocd_pkg::CAL_SAMPLES_DEF,
    parameter int RESTART_COUNT = gocd_pkg::RESTART_COUNT_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_fire,
    input  logic                 i_cmd,
    input  logic                 i_failsafe,
    input  logic                 i_tilt,
    output gocd_pkg::t_cal_ctrl  o_ctrl
);
    import gocd_pkg::*;

    localparam logic [CNT_W-1:0] CAL_CNT     = CNT_W'(CAL_SAMPLES);
    localparam logic [3:0]       CAL_MOD     = 4'(CAL_SAMPLES % 10);
    localparam logic [CNT_W-1:0] RESTART_CNT = CNT_W'(RESTART_COUNT);
    localparam logic [3:0]       RESTART_MOD = 4'(RESTART_COUNT % 10);

    logic [CNT_W-1:0] r_count, n_count, cnt_eff;
    logic [3:0]       r_mod10, n_mod10, mod_eff;

    always_comb begin
        cnt_eff = i_cmd ? CAL_CNT : r_count;
        mod_eff = i_cmd ? CAL_MOD : r_mod10;

        o_ctrl.fire     = i_fire;
        o_ctrl.cal      = (cnt_eff != '0);
        o_ctrl.first    = (cnt_eff == CAL_CNT);
        o_ctrl.done     = (cnt_eff == CNT_W'(1));
        o_ctrl.check    = i_failsafe && (cnt_eff != '0) && (mod_eff == 4'd0);
        o_ctrl.failsafe = i_failsafe;

        n_count = r_count;
        n_mod10 = r_mod10;
        if (i_fire && (cnt_eff != '0)) begin
            if (i_tilt) begin
                n_count = RESTART_CNT;
                n_mod10 = RESTART_MOD;
            end else begin
                n_count = cnt_eff - CNT_W'(1);
                n_mod10 = (mod_eff == 4'd0) ? 4'd9 : mod_eff - 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_mod10 <= '0;
        end else begin
            r_count <= n_count;
            r_mod10 <= n_mod10;
        end
    end

endmodule

// File: hdl/gocd_axis.sv
// One axis: calibration sum, offset, tilt compare and glitch limiter.
// Holds the sum, offset and last output of its axis.
// Depends on gocd_pkg.
module gocd_axis (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  gocd_pkg::t_cal_ctrl                  i_ctrl,
    input  logic signed [gocd_pkg::RATE_W-1:0]   i_rate,
    input  logic        [gocd_pkg::CFG_W-1:0]    i_tilt_thr,
    input  logic        [gocd_pkg::CFG_W-1:0]    i_glitch,
    output logic signed [gocd_pkg::OUT_W-1:0]    o_out,
    output logic                                 o_tilt
);
    import gocd_pkg::*;

    localparam int LW = OUT_W + 2;

    logic signed [SUM_W-1:0]  r_sum, n_sum, sum_base, rnd;
    logic signed [RATE_W-1:0] r_off, n_off, off_cal;
    logic signed [OUT_W-1:0]  r_last, n_last, last_a, smp16, res;
    logic signed [OUT_W:0]    diff, diff_abs;
    logic signed [LW-1:0]     prev, gl, lo, hi, v, c;

    always_comb begin
        smp16    = {{(OUT_W-RATE_W){i_rate[RATE_W-1]}}, i_rate};
        sum_base = i_ctrl.first ? '0 : r_sum;
        n_sum    = sum_base + {{(SUM_W-RATE_W){i_rate[RATE_W-1]}}, i_rate};
        rnd      = n_sum + SUM_W'(256);
        off_cal  = i_ctrl.done ? rnd[OFF_SHIFT+RATE_W-1:OFF_SHIFT] : '0;

        last_a   = (i_ctrl.failsafe && i_ctrl.first) ? smp16 : r_last;
        diff     = {smp16[OUT_W-1], smp16} - {last_a[OUT_W-1], last_a};
        diff_abs = diff[OUT_W] ? -diff : diff;
        o_tilt   = i_ctrl.check && (diff_abs > $signed({3'b000, i_tilt_thr}));

        prev = {{2{r_last[OUT_W-1]}}, r_last};
        gl   = {{(LW-CFG_W){1'b0}}, i_glitch};
        lo   = prev - gl;
        hi   = prev + gl;
        if (i_ctrl.cal)
            v = -{{(LW-RATE_W){off_cal[RATE_W-1]}}, off_cal};
        else
            v = {{(LW-RATE_W){i_rate[RATE_W-1]}}, i_rate}
                - {{(LW-RATE_W){r_off[RATE_W-1]}}, r_off};
        if (v < lo)
            c = lo;
        else if (v > hi)
            c = hi;
        else
            c = v;
        if (c < -LW'(32768))
            res = 16'sh8000;
        else if (c > LW'(32767))
            res = 16'sh7fff;
        else
            res = c[OUT_W-1:0];

        n_off  = r_off;
        n_last = r_last;
        o_out  = res;
        if (i_ctrl.cal) begin
            n_off = off_cal;
            if (i_ctrl.failsafe) begin
                o_out  = '0;
                n_last = i_ctrl.check ? smp16 : last_a;
            end else begin
                n_last = res;
            end
        end else begin
            n_last = res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.fire && i_ctrl.cal)
            r_sum <= n_sum;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_off  <= '0;
            r_last <= '0;
        end else if (i_ctrl.fire) begin
            r_off  <= n_off;
            r_last <= n_last;
        end
    end

endmodule

// File: hdl/gyro_offset_calibrate_deglitch.sv
// Gyro offset calibration with tilt failsafe and glitch limiter, top level.
// Input register, sequencer, three axis datapaths and output register.
// Depends on gocd_pkg, gocd_ctrl and gocd_axis.
//
// Usage: one three-axis sample per request on the s_axis channel (tuser = start
// calibration command), one corrected sample per request on m_axis with flags
// calibrating, calib_done and tilt_seen in tuser. A start command runs a
// CAL_SAMPLES-long calibration; with failsafe on, movement beyond the tilt
// threshold restarts the countdown at RESTART_COUNT.
// A request accepted into the input register passes to the output register when
// the output register is free or being read; throughput is one request per cycle
// while the receiver keeps up, as offsets and last outputs update on each request.
// The input register can still take one request while a finished result waits in the
// output register; when the receiver stalls, both registers fill and s_axis_tready
// drops until m_axis_tready returns. Reset clears the countdown, offsets, last
// outputs and valid flags, and loads the register defaults (failsafe off, tilt
// threshold 8, glitch limit 800). Write configuration only while idle.
module gyro_offset_calibrate_deglitch #(
    parameter int CAL_SAMPLES   = gocd_pkg::CAL_SAMPLES_DEF,
    parameter int RESTART_COUNT = gocd_pkg::RESTART_COUNT_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [gocd_pkg::CFG_AW-1:0]  i_cfg_addr,
    input  logic [gocd_pkg::CFG_W-1:0]   i_cfg_wdata,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [47:0]                  s_axis_tdata,  // rate_x, rate_y, rate_z, 6'b0
    input  logic                         s_axis_tuser,  // cmd
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [47:0]                  m_axis_tdata,  // out_x, out_y, out_z
    output logic [2:0]                   m_axis_tuser   // calibrating, calib_done, tilt_seen
);
    import gocd_pkg::*;

    logic              r_failsafe;
    logic [CFG_W-1:0]  r_tilt_thr, r_glitch;

    logic                     r_in_valid, r_in_cmd;
    logic signed [RATE_W-1:0] r_in_rate [3];

    logic                     r_out_valid, r_out_cal, r_out_done, r_out_tilt;
    logic signed [OUT_W-1:0]  r_out [3];

    logic                     advance, fire, tilt_any;
    logic [2:0]               axis_tilt;
    logic signed [OUT_W-1:0]  axis_out [3];
    t_cal_ctrl                ctrl;

    assign advance       = !r_out_valid || m_axis_tready;
    assign fire          = r_in_valid && advance;
    assign s_axis_tready = !r_in_valid || advance;
    assign tilt_any      = |axis_tilt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_failsafe <= FAILSAFE_RST;
            r_tilt_thr <= TILT_RST;
            r_glitch   <= GLITCH_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_FAILSAFE: r_failsafe <= i_cfg_wdata[0];
                CFG_TILT:     r_tilt_thr <= i_cfg_wdata;
                CFG_GLITCH:   r_glitch   <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_in_valid <= 1'b0;
        else if (s_axis_tready)
            r_in_valid <= s_axis_tvalid;
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_cmd     <= s_axis_tuser;
            r_in_rate[0] <= s_axis_tdata[RATE_W-1:0];
            r_in_rate[1] <= s_axis_tdata[2*RATE_W-1:RATE_W];
            r_in_rate[2] <= s_axis_tdata[3*RATE_W-1:2*RATE_W];
        end
    end

    gocd_ctrl #(
        .CAL_SAMPLES   (CAL_SAMPLES),
        .RESTART_COUNT (RESTART_COUNT)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (fire),
        .i_cmd      (r_in_cmd),
        .i_failsafe (r_failsafe),
        .i_tilt     (tilt_any),
        .o_ctrl     (ctrl)
    );

    for (genvar a = 0; a < 3; a++) begin : g_axis
        gocd_axis u_axis (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctrl     (ctrl),
            .i_rate     (r_in_rate[a]),
            .i_tilt_thr (r_tilt_thr),
            .i_glitch   (r_glitch),
            .o_out      (axis_out[a]),
            .o_tilt     (axis_tilt[a])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_out_valid <= 1'b0;
        else if (advance)
            r_out_valid <= r_in_valid;
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out[0]   <= axis_out[0];
            r_out[1]   <= axis_out[1];
            r_out[2]   <= axis_out[2];
            r_out_cal  <= ctrl.cal;
            r_out_done <= ctrl.done;
            r_out_tilt <= tilt_any;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out[2], r_out[1], r_out[0]};
    assign m_axis_tuser  = {r_out_tilt, r_out_done, r_out_cal};

endmodule
